>>> hw/rtl/sbq_pkg.sv
// shared types and constants for the stereo biquad filter core
`timescale 1ns / 1ps
`default_nettype none

package sbq_pkg;

    // coefficient format and register file
    localparam int COEF_BITS        = 18;
    localparam int NUM_COEFS        = 5;
    localparam int CFG_IDX_W        = 3;
    localparam int SAMPLE_BITS_DEF  = 24;
    localparam int COEF_FRAC_DEF    = 16;

    // reset value of the current-sample gain
    localparam logic [COEF_BITS-1:0] B0_RESET = 18'h10000;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        IDX_B0 = 3'd0,
        IDX_B1 = 3'd1,
        IDX_B2 = 3'd2,
        IDX_A1 = 3'd3,
        IDX_A2 = 3'd4
    } coef_idx_t;

    // the five shared coefficients
    typedef struct packed {
        logic [COEF_BITS-1:0] b0;
        logic [COEF_BITS-1:0] b1;
        logic [COEF_BITS-1:0] b2;
        logic [COEF_BITS-1:0] a1;
        logic [COEF_BITS-1:0] a2;
    } coef_t;

    // pipeline advance strobes sent to the lanes
    typedef struct packed {
        logic accept;
        logic adv_b;
        logic adv_o;
    } lane_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/stereo_biquad_filter_core.sv
// top level of the stereo biquad filter: handshake pipeline, coefficients, two lanes
// pipeline: three register stages (va_reg, vb_reg, vo_reg) from acceptance to m_valid
// throughput: one stereo transaction per cycle while m_ready does not stall, set by the single
//   multiply-accumulate feedback path through the a1 product in each lane
// reset: history cleared to zero, b0 = 1.0, other coefficients zero, pipeline empty
`timescale 1ns / 1ps
`default_nettype none

module stereo_biquad_filter_core #(
    parameter int SAMPLE_BITS    = sbq_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = sbq_pkg::COEF_FRAC_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [sbq_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  wire logic [sbq_pkg::COEF_BITS-1:0]     cfg_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]     s_left_in,
    input  wire logic signed [SAMPLE_BITS-1:0]     s_right_in,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [SAMPLE_BITS-1:0]          m_left_out,
    output logic signed [SAMPLE_BITS-1:0]          m_right_out
);

    sbq_pkg::coef_t      coef;
    sbq_pkg::lane_ctrl_t ctrl;

    logic va_reg, vb_reg, vo_reg;
    logic va_next, vb_next, vo_next;
    logic o_ready, b_ready;

    // stage readiness chained back from the result port
    assign o_ready     = !vo_reg || m_ready;
    assign ctrl.adv_o  = vb_reg && o_ready;
    assign b_ready     = !vb_reg || ctrl.adv_o;
    assign ctrl.adv_b  = va_reg && b_ready;
    assign s_ready     = !va_reg || ctrl.adv_b;
    assign ctrl.accept = s_valid && s_ready;

    // stage occupancy
    always_comb begin
        va_next = ctrl.accept || (va_reg && !ctrl.adv_b);
        vb_next = ctrl.adv_b || (vb_reg && !ctrl.adv_o);
        vo_next = ctrl.adv_o || (vo_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            va_reg <= va_next;
            vb_reg <= vb_next;
            vo_reg <= vo_next;
        end
    end

    // shared coefficient registers
    sbq_coef_regs u_coef (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .coef     (coef)
    );

    // left and right lanes run in lockstep
    sbq_lane #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .coef    (coef),
        .x_in    (s_left_in),
        .y_out   (m_left_out)
    );

    sbq_lane #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .coef    (coef),
        .x_in    (s_right_in),
        .y_out   (m_right_out)
    );

    assign m_valid = vo_reg;

endmodule

`default_nettype wire

>>> hw/rtl/sbq_coef_regs.sv
// coefficient register file written through the configuration port
`timescale 1ns / 1ps
`default_nettype none

module sbq_coef_regs (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [sbq_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  wire logic [sbq_pkg::COEF_BITS-1:0]      cfg_data,
    output sbq_pkg::coef_t                          coef
);

    sbq_pkg::coef_t coef_reg;
    sbq_pkg::coef_t coef_next;

    // index decode, out-of-range writes are dropped
    always_comb begin
        coef_next = coef_reg;
        if (cfg_we) begin
            unique case (cfg_idx)
                sbq_pkg::IDX_B0: coef_next.b0 = cfg_data;
                sbq_pkg::IDX_B1: coef_next.b1 = cfg_data;
                sbq_pkg::IDX_B2: coef_next.b2 = cfg_data;
                sbq_pkg::IDX_A1: coef_next.a1 = cfg_data;
                sbq_pkg::IDX_A2: coef_next.a2 = cfg_data;
                default:         coef_next    = coef_reg;
            endcase
        end
    end

    // register update with unity-gain reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.b0 <= sbq_pkg::B0_RESET;
            coef_reg.b1 <= '0;
            coef_reg.b2 <= '0;
            coef_reg.a1 <= '0;
            coef_reg.a2 <= '0;
        end else begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

`default_nettype wire

>>> hw/rtl/sbq_lane.sv
// one channel of the biquad: history, feed-forward products and feedback loop
`timescale 1ns / 1ps
`default_nettype none

module sbq_lane #(
    parameter int SAMPLE_BITS    = sbq_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = sbq_pkg::COEF_FRAC_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire sbq_pkg::lane_ctrl_t           ctrl,
    input  wire sbq_pkg::coef_t                coef,
    input  wire logic signed [SAMPLE_BITS-1:0] x_in,
    output logic signed [SAMPLE_BITS-1:0]      y_out
);

    localparam int PROD_W = sbq_pkg::COEF_BITS + SAMPLE_BITS;
    localparam int ACC_A  = PROD_W + 3;
    localparam int ACC_B  = COEF_FRAC_BITS + 2;
    localparam int ACC_W  = (ACC_A > ACC_B) ? ACC_A : ACC_B;
    localparam int EXT    = ACC_W - PROD_W;

    localparam logic signed [ACC_W-1:0] RND  = ACC_W'(64'd1 << (COEF_FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SMIN = ACC_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
    localparam logic signed [SAMPLE_BITS-1:0] YMAX = SAMPLE_BITS'(SMAX);
    localparam logic signed [SAMPLE_BITS-1:0] YMIN = SAMPLE_BITS'(SMIN);

    logic signed [sbq_pkg::COEF_BITS-1:0] c_b0, c_b1, c_b2, c_a1, c_a2;

    logic signed [SAMPLE_BITS-1:0] x1_reg, x2_reg;
    logic signed [SAMPLE_BITS-1:0] y1_reg, y2_reg;
    logic signed [PROD_W-1:0]      p0_reg, p1_reg, p2_reg;
    logic signed [PROD_W-1:0]      a2y2_reg, a2y2_next;
    logic signed [ACC_W-1:0]       ffr_reg, ffr_next;

    logic signed [PROD_W-1:0]      a1y1;
    logic signed [ACC_W-1:0]       acc;
    logic signed [ACC_W-1:0]       ysh;
    logic signed [SAMPLE_BITS-1:0] y1_next;

    assign c_b0 = $signed(coef.b0);
    assign c_b1 = $signed(coef.b1);
    assign c_b2 = $signed(coef.b2);
    assign c_a1 = $signed(coef.a1);
    assign c_a2 = $signed(coef.a2);

    // input history shifts on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x1_reg <= '0;
            x2_reg <= '0;
        end else if (ctrl.accept) begin
            x1_reg <= x_in;
            x2_reg <= x1_reg;
        end
    end

    // feed-forward products
    always_ff @(posedge aclk) begin
        if (ctrl.accept) begin
            p0_reg <= c_b0 * x_in;
            p1_reg <= c_b1 * x1_reg;
            p2_reg <= c_b2 * x2_reg;
        end
    end

    // feed-forward sum with rounding offset folded in
    assign ffr_next = {{EXT{p0_reg[PROD_W-1]}}, p0_reg}
                    + {{EXT{p1_reg[PROD_W-1]}}, p1_reg}
                    + {{EXT{p2_reg[PROD_W-1]}}, p2_reg}
                    + RND;

    always_ff @(posedge aclk) begin
        if (ctrl.adv_b) begin
            ffr_reg <= ffr_next;
        end
    end

    // feedback: one multiply, subtract, round by floor shift, saturate
    assign a1y1 = c_a1 * y1_reg;
    assign acc  = ffr_reg
                - {{EXT{a2y2_reg[PROD_W-1]}}, a2y2_reg}
                - {{EXT{a1y1[PROD_W-1]}}, a1y1};
    assign ysh  = acc >>> COEF_FRAC_BITS;

    always_comb begin
        if (ysh > SMAX) begin
            y1_next = YMAX;
        end else if (ysh < SMIN) begin
            y1_next = YMIN;
        end else begin
            y1_next = ysh[SAMPLE_BITS-1:0];
        end
    end

    // a2 term for the next output, refreshed while idle to follow coefficient writes
    always_comb begin
        if (ctrl.adv_o) begin
            a2y2_next = c_a2 * y1_reg;
        end else begin
            a2y2_next = c_a2 * y2_reg;
        end
    end

    // output history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y1_reg   <= '0;
            y2_reg   <= '0;
            a2y2_reg <= '0;
        end else begin
            a2y2_reg <= a2y2_next;
            if (ctrl.adv_o) begin
                y1_reg <= y1_next;
                y2_reg <= y1_reg;
            end
        end
    end

    assign y_out = y1_reg;

endmodule

`default_nettype wire
